// ===== rtl/sgac_pkg.sv =====
// ----------------------------------------------------------------------------
// sgac_pkg
// Shared constants and the queue entry type for the segment gap check.
// ----------------------------------------------------------------------------
package sgac_pkg;

  localparam int unsigned CLICK_BITS_DEF = 8;
  localparam int unsigned PAGE_BITS_DEF  = 13;
  localparam int unsigned PAGE_LIMIT_DEF = 8;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned BYTE_W  = 24;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    FUNC_BRK   = 1'b0,
    FUNC_FAULT = 1'b1
  } func_t;

  typedef struct packed {
    logic               func;
    logic               separate_space;
    logic               ok;
    logic               stack_grew;
    logic [FIELD_W-1:0] text_len;
    logic [FIELD_W-1:0] data_vir;
    logic [FIELD_W-1:0] data_len;
    logic [FIELD_W-1:0] want;
    logic [FIELD_W-1:0] stack_vir;
    logic [FIELD_W-1:0] stack_phys;
    logic [FIELD_W-1:0] stack_len;
    logic [FIELD_W-1:0] new_vir;
    logic [FIELD_W-1:0] new_phys;
    logic [FIELD_W-1:0] new_len;
  } item_t;

endpackage

// ===== rtl/sgac_if.sv =====
// ----------------------------------------------------------------------------
// sgac_if
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sgac_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [23:0] brk_bytes;
  logic [23:0] stack_pointer;
  logic        separate_space;
  logic [15:0] text_len_in;
  logic [15:0] data_vir_in;
  logic [15:0] data_len_in;
  logic [15:0] stack_vir_in;
  logic [15:0] stack_phys_in;
  logic [15:0] stack_len_in;

  modport source (
    output valid, func, brk_bytes, stack_pointer, separate_space, text_len_in,
           data_vir_in, data_len_in, stack_vir_in, stack_phys_in, stack_len_in,
    input  ready
  );
  modport sink (
    input  valid, func, brk_bytes, stack_pointer, separate_space, text_len_in,
           data_vir_in, data_len_in, stack_vir_in, stack_phys_in, stack_len_in,
    output ready
  );
endinterface

interface sgac_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        kill_process;
  logic        map_changed;
  logic [15:0] data_len_out;
  logic [15:0] stack_vir_out;
  logic [15:0] stack_phys_out;
  logic [15:0] stack_len_out;

  modport source (
    output valid, status, kill_process, map_changed, data_len_out,
           stack_vir_out, stack_phys_out, stack_len_out,
    input  ready
  );
  modport sink (
    input  valid, status, kill_process, map_changed, data_len_out,
           stack_vir_out, stack_phys_out, stack_len_out,
    output ready
  );
endinterface

// ===== rtl/sgac_front.sv =====
// ----------------------------------------------------------------------------
// sgac_front
// Accepts a request, sizes the data segment and runs the stack/gap checks.
// ----------------------------------------------------------------------------
module sgac_front #(
  parameter int unsigned CLICK_BITS = sgac_pkg::CLICK_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  sgac_req_if.sink       req,
  output sgac_pkg::item_t item,
  output logic           item_valid,
  input  logic           item_ready
);

  localparam int unsigned CLICK_ROUND = (1 << CLICK_BITS) - 1;

  logic [24:0] brk_sum;
  logic [24:0] brk_clicks;
  logic        too_big;
  logic [15:0] want;
  logic [23:0] ptr_click;
  logic [16:0] stack_top;
  logic        sp_high;
  logic        below;
  logic [15:0] lower;
  logic [16:0] data_end;
  logic        collide;
  logic [15:0] delta;
  logic [16:0] grow_sum;
  logic        overflow;
  logic        accept;
  sgac_pkg::item_t item_next;

  assign brk_sum    = {1'b0, req.brk_bytes} + 25'(CLICK_ROUND);
  assign brk_clicks = brk_sum >> CLICK_BITS;
  assign too_big    = (req.func == sgac_pkg::FUNC_BRK) && (brk_clicks[24:16] != '0);
  assign want       = (req.func == sgac_pkg::FUNC_FAULT) ? req.data_len_in
                                                         : brk_clicks[15:0];

  assign ptr_click = req.stack_pointer >> CLICK_BITS;
  assign stack_top = {1'b0, req.stack_vir_in} + {1'b0, req.stack_len_in};
  assign sp_high   = ptr_click >= {7'b0, stack_top};
  assign below     = ptr_click < {8'b0, req.stack_vir_in};
  assign lower     = below ? ptr_click[15:0] : req.stack_vir_in;
  assign data_end  = {1'b0, req.data_vir_in} + {1'b0, want};
  assign collide   = {1'b0, lower} < data_end;

  assign delta    = below ? (req.stack_vir_in - ptr_click[15:0]) : '0;
  assign grow_sum = {1'b0, req.stack_len_in} + {1'b0, delta};
  assign overflow = below && ((req.stack_phys_in < delta) || grow_sum[16]);

  always_comb begin
    item_next.func           = req.func;
    item_next.separate_space = req.separate_space;
    item_next.ok             = !too_big && !sp_high && !collide && !overflow;
    item_next.stack_grew     = below;
    item_next.text_len       = req.text_len_in;
    item_next.data_vir       = req.data_vir_in;
    item_next.data_len       = req.data_len_in;
    item_next.want           = want;
    item_next.stack_vir      = req.stack_vir_in;
    item_next.stack_phys     = req.stack_phys_in;
    item_next.stack_len      = req.stack_len_in;
    item_next.new_vir        = req.stack_vir_in - delta;
    item_next.new_phys       = req.stack_phys_in - delta;
    item_next.new_len        = grow_sum[15:0];
  end

  assign req.ready = !item_valid || item_ready;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

// ===== rtl/sgac_queue.sv =====
// ----------------------------------------------------------------------------
// sgac_queue
// Short FIFO between the front and back halves.
// ----------------------------------------------------------------------------
module sgac_queue (
  input  logic            clk,
  input  logic            rst,
  input  sgac_pkg::item_t push_item,
  input  logic            push_valid,
  output logic            push_ready,
  output sgac_pkg::item_t pop_item,
  output logic            pop_valid,
  input  logic            pop_ready
);

  localparam int unsigned DEPTH = sgac_pkg::QUEUE_DEPTH;

  sgac_pkg::item_t                 entries [DEPTH];
  logic [sgac_pkg::QPTR_W-1:0]     wr_ptr;
  logic [sgac_pkg::QPTR_W-1:0]     rd_ptr;
  logic [sgac_pkg::QCNT_W-1:0]     count;
  logic                            push;
  logic                            pop;

  assign push_ready = count != sgac_pkg::QCNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == sgac_pkg::QPTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == sgac_pkg::QPTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sgac_pkg::QCNT_W'(DEPTH))
    else $error("queue count above depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");
`endif

endmodule

// ===== rtl/sgac_back.sv =====
// ----------------------------------------------------------------------------
// sgac_back
// Page accounting and final result; drives the registered result channel.
// ----------------------------------------------------------------------------
module sgac_back #(
  parameter int unsigned CLICK_BITS = sgac_pkg::CLICK_BITS_DEF,
  parameter int unsigned PAGE_BITS  = sgac_pkg::PAGE_BITS_DEF,
  parameter int unsigned PAGE_LIMIT = sgac_pkg::PAGE_LIMIT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  sgac_pkg::item_t item,
  input  logic            item_valid,
  output logic            item_ready,
  sgac_rsp_if.source      rsp
);

  localparam int unsigned PW         = 17 + CLICK_BITS;
  localparam int unsigned SW         = PW + 2;
  localparam int unsigned PAGE_ROUND = (1 << PAGE_BITS) - 1;

  function automatic logic [PW-1:0] pages_of(input logic [15:0] clicks);
    logic [PW-1:0] bytes_v;
    bytes_v = PW'(clicks) << CLICK_BITS;
    return (bytes_v + PW'(PAGE_ROUND)) >> PAGE_BITS;
  endfunction

  logic [PW-1:0] pt;
  logic [PW-1:0] pd;
  logic [PW-1:0] ps;
  logic [SW-1:0] ds_sum;
  logic [SW-1:0] all_sum;
  logic          page_fail;
  logic [16:0]   data_end;
  logic          ok;
  logic          take;

  assign pt      = pages_of(item.text_len);
  assign pd      = pages_of(item.want);
  assign ps      = pages_of(item.new_len);
  assign ds_sum  = SW'(pd) + SW'(ps);
  assign all_sum = ds_sum + SW'(pt);

  assign page_fail = item.separate_space
                   ? ((SW'(pt) > SW'(PAGE_LIMIT)) || (ds_sum > SW'(PAGE_LIMIT)))
                   : (all_sum > SW'(PAGE_LIMIT));
  assign data_end  = {1'b0, item.data_vir} + {1'b0, item.want};
  assign ok        = item.ok && !page_fail && (data_end <= {1'b0, item.new_vir});

  assign item_ready = !rsp.valid || rsp.ready;
  assign take       = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (take) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (ok) begin
        rsp.status         <= 1'b0;
        rsp.kill_process   <= 1'b0;
        rsp.map_changed    <= (item.want != item.data_len) || item.stack_grew;
        rsp.data_len_out   <= item.want;
        rsp.stack_vir_out  <= item.new_vir;
        rsp.stack_phys_out <= item.new_phys;
        rsp.stack_len_out  <= item.new_len;
      end else begin
        rsp.status         <= 1'b1;
        rsp.kill_process   <= item.func;
        rsp.map_changed    <= 1'b0;
        rsp.data_len_out   <= item.data_len;
        rsp.stack_vir_out  <= item.stack_vir;
        rsp.stack_phys_out <= item.stack_phys;
        rsp.stack_len_out  <= item.stack_len;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_ok_no_kill: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.status) |-> !rsp.kill_process)
    else $error("kill raised on accepted request");
  a_fail_no_change: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status) |-> !rsp.map_changed)
    else $error("map change flagged on failed request");
`endif

endmodule

// ===== rtl/segment_gap_adjust_check.sv =====
// Path: an accepted request passes the front register, a queue entry and
// the result register; it waits in them while the result side stalls.
// Throughput: one request per cycle unless stalled; the 2-entry queue absorbs short stalls.
// Reset (rst, synchronous): empties the front register, queue and result
// register; no other state.
// ----------------------------------------------------------------------------
// segment_gap_adjust_check
// Data-segment resize and stack-fault check against the gap and page limit.
// ----------------------------------------------------------------------------
module segment_gap_adjust_check #(
  parameter int unsigned CLICK_BITS = sgac_pkg::CLICK_BITS_DEF,
  parameter int unsigned PAGE_BITS  = sgac_pkg::PAGE_BITS_DEF,
  parameter int unsigned PAGE_LIMIT = sgac_pkg::PAGE_LIMIT_DEF
) (
  input logic        clk,
  input logic        rst,
  sgac_req_if.sink   req,
  sgac_rsp_if.source rsp
);

  sgac_pkg::item_t front_item;
  logic            front_valid;
  logic            front_ready;
  sgac_pkg::item_t back_item;
  logic            back_valid;
  logic            back_ready;

  sgac_front #(
    .CLICK_BITS (CLICK_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .item       (front_item),
    .item_valid (front_valid),
    .item_ready (front_ready)
  );

  sgac_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (front_item),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_item   (back_item),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  sgac_back #(
    .CLICK_BITS (CLICK_BITS),
    .PAGE_BITS  (PAGE_BITS),
    .PAGE_LIMIT (PAGE_LIMIT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (back_item),
    .item_valid (back_valid),
    .item_ready (back_ready),
    .rsp        (rsp)
  );

endmodule
